// ===== rtl/core/hvno_pkg.sv =====
`timescale 1ns / 1ps

package hvno_pkg;

  localparam int unsigned DEF_MAX_LEVELS = 4;
  localparam int unsigned DEF_TABLE_BITS = 20;

  localparam logic [31:0] HASH_MUL_X = 32'd487211441;
  localparam logic [31:0] HASH_MUL_Y = 32'd21771;

  localparam logic [2:0]  LEVEL_COUNT_RST = 3'd1;
  localparam logic [31:0] SCALE_RST       = 32'd16777216;

  localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;
  localparam logic [1:0] REG_X_SCALE     = 2'd1;
  localparam logic [1:0] REG_Y_SCALE     = 2'd2;
  localparam logic [1:0] REG_Z_SCALE     = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef struct packed {
    logic [2:0]  level_count;
    logic [31:0] x_scale;
    logic [31:0] y_scale;
    logic [31:0] z_scale;
  } hvno_cfg_t;

  typedef struct packed {
    logic        operation;
    logic [1:0]  level_index;
    logic [19:0] table_address;
    logic [7:0]  table_data;
    logic [47:0] x_coord;
    logic [47:0] y_coord;
    logic [47:0] z_coord;
  } hvno_cmd_t;

endpackage

// ===== rtl/core/hashed_value_noise_octaves_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      operation, level, address, data, x/y/z
// out      output     out_valid / out_ready    noise_value
// cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A table write is done in the back end as the command leaves the queue. An
// evaluation runs nine 16 by 32 bit partial products for the three axes, then
// per octave eight reads from the single-port table plus hashing and seven
// shared blend steps. Reset is synchronous and clears the control state, the
// config registers and the sum; datapath registers and the table are not cleared.
// A two-word queue lets the input side accept two commands while a result stalls.
module hashed_value_noise_octaves_unit #(
  parameter int unsigned MAX_LEVELS = hvno_pkg::DEF_MAX_LEVELS,
  parameter int unsigned TABLE_BITS = hvno_pkg::DEF_TABLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [1:0]  in_level_index,
  input  logic [19:0] in_table_address,
  input  logic [7:0]  in_table_data,
  input  logic [47:0] in_x_coord,
  input  logic [47:0] in_y_coord,
  input  logic [47:0] in_z_coord,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [24:0] out_noise_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hvno_pkg::*;

  hvno_cfg_t cfg_r;
  hvno_cmd_t in_cmd;
  hvno_cmd_t head_cmd;
  logic      head_valid;
  logic      head_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_cmd.operation     = in_operation;
    in_cmd.level_index   = in_level_index;
    in_cmd.table_address = in_table_address;
    in_cmd.table_data    = in_table_data;
    in_cmd.x_coord       = in_x_coord;
    in_cmd.y_coord       = in_y_coord;
    in_cmd.z_coord       = in_z_coord;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_count <= LEVEL_COUNT_RST;
      cfg_r.x_scale     <= SCALE_RST;
      cfg_r.y_scale     <= SCALE_RST;
      cfg_r.z_scale     <= SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEVEL_COUNT: cfg_r.level_count <= cfg_data[2:0];
        REG_X_SCALE:     cfg_r.x_scale     <= cfg_data;
        REG_Y_SCALE:     cfg_r.y_scale     <= cfg_data;
        REG_Z_SCALE:     cfg_r.z_scale     <= cfg_data;
        default:         cfg_r.z_scale     <= cfg_r.z_scale;
      endcase
    end
  end

  hvno_front #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_pop   (head_pop)
  );

  hvno_back #(
    .MAX_LEVELS (MAX_LEVELS),
    .TABLE_BITS (TABLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .head_pop        (head_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_noise_value (out_noise_value)
  );

endmodule

// ===== rtl/core/hvno_front.sv =====
`timescale 1ns / 1ps

module hvno_front #(
  parameter int unsigned MAX_LEVELS = hvno_pkg::DEF_MAX_LEVELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hvno_pkg::hvno_cmd_t in_cmd,
  output logic               head_valid,
  output hvno_pkg::hvno_cmd_t head_cmd,
  input  logic               head_pop
);
  import hvno_pkg::*;

  hvno_cmd_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep;
  logic       push;
  logic       pop;

  // Writes to a table beyond the last octave table are dropped here.
  assign keep = (in_cmd.operation == OP_EVAL) ||
                (32'(in_cmd.level_index) < MAX_LEVELS);
  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready && keep;
  assign head_valid = (cnt_r != 2'd0);
  assign pop        = head_pop && head_valid;
  assign head_cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ===== rtl/core/hvno_back.sv =====
`timescale 1ns / 1ps

module hvno_back #(
  parameter int unsigned MAX_LEVELS = hvno_pkg::DEF_MAX_LEVELS,
  parameter int unsigned TABLE_BITS = hvno_pkg::DEF_TABLE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hvno_pkg::hvno_cfg_t cfg,
  input  logic                head_valid,
  input  hvno_pkg::hvno_cmd_t head_cmd,
  output logic                head_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [24:0]         out_noise_value
);
  import hvno_pkg::*;

  localparam int unsigned LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned OCT_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned ADDR_W = LVL_W + TABLE_BITS;
  localparam int unsigned DEPTH = MAX_LEVELS * (2 ** TABLE_BITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_HASH1 = 4'd3;
  localparam logic [3:0] S_HASH2 = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_BLEND = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [15:0] t);
    logic signed [8:0]  d;
    logic signed [25:0] p;
    logic signed [9:0]  q;
    logic [9:0]         r;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = 26'(d) * 26'($signed({1'b0, t}));
    q = 10'(p >>> 16);
    r = {2'b00, a} + q;
    return r[7:0];
  endfunction

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rd_data_r;
  logic [ADDR_W-1:0] mem_addr;
  logic        mem_we;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic [1:0]  part_r, part_nxt;
  logic [OCT_W-1:0] oct_r, oct_nxt;
  logic [OCT_W-1:0] n_r, n_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [47:0] cx_r, cy_r, cz_r;
  logic [71:0] acc_r, px_r, py_r, pz_r;
  logic [31:0] xi_r, yi_r, zi_r;
  logic [15:0] xl_r, yl_r, zl_r;
  logic [31:0] x0_r, h00_r, h10_r;
  logic [7:0]  byte_r [8];
  logic [24:0] sum_r;
  logic [24:0] noise_r;

  logic [47:0] m_coord;
  logic [31:0] m_scale;
  logic [15:0] m_chunk;
  logic [16:0] m_ext;
  logic signed [49:0] m_pp;
  logic [71:0] m_add;
  logic [71:0] acc_nxt;
  logic [71:0] psx, psy, psz;
  logic [31:0] f_base;
  logic [31:0] f_hash;
  logic [7:0]  b_a, b_b, b_res;
  logic [15:0] b_t;
  logic [2:0]  b_dst;
  logic [23:0] res_sh;
  logic [OCT_W-1:0] n_cfg;

  assign out_valid       = out_valid_r;
  assign out_noise_value = noise_r;

  always_comb begin
    unique case (axis_r)
      2'd0:    begin m_coord = cx_r; m_scale = cfg.x_scale; end
      2'd1:    begin m_coord = cy_r; m_scale = cfg.y_scale; end
      default: begin m_coord = cz_r; m_scale = cfg.z_scale; end
    endcase
    case (part_r)
      2'd0:    m_chunk = m_coord[15:0];
      2'd1:    m_chunk = m_coord[31:16];
      default: m_chunk = m_coord[47:32];
    endcase
    m_ext   = (part_r == 2'd2) ? {m_coord[47], m_chunk} : {1'b0, m_chunk};
    m_pp    = 50'($signed(m_ext)) * 50'($signed({1'b0, m_scale}));
    m_add   = {{22{m_pp[49]}}, m_pp} << (16 * part_r);
    acc_nxt = ((part_r == 2'd0) ? 72'd0 : acc_r) + m_add;
  end

  always_comb begin
    psx = px_r << oct_r;
    psy = py_r << oct_r;
    psz = pz_r << oct_r;
  end

  always_comb begin
    f_base = fcnt_r[0] ? h10_r : h00_r;
    f_hash = f_base + (fcnt_r[1] ? HASH_MUL_Y : 32'd0) + zi_r + 32'(fcnt_r[2]);
  end

  always_comb begin
    case (step_r)
      3'd0:    begin b_a = byte_r[0]; b_b = byte_r[1]; b_t = xl_r; b_dst = 3'd0; end
      3'd1:    begin b_a = byte_r[2]; b_b = byte_r[3]; b_t = xl_r; b_dst = 3'd2; end
      3'd2:    begin b_a = byte_r[4]; b_b = byte_r[5]; b_t = xl_r; b_dst = 3'd4; end
      3'd3:    begin b_a = byte_r[6]; b_b = byte_r[7]; b_t = xl_r; b_dst = 3'd6; end
      3'd4:    begin b_a = byte_r[0]; b_b = byte_r[2]; b_t = yl_r; b_dst = 3'd0; end
      3'd5:    begin b_a = byte_r[4]; b_b = byte_r[6]; b_t = yl_r; b_dst = 3'd4; end
      default: begin b_a = byte_r[0]; b_b = byte_r[4]; b_t = zl_r; b_dst = 3'd0; end
    endcase
    b_res  = blend(b_a, b_b, b_t);
    res_sh = {b_res, 16'h0000} >> oct_r;
  end

  always_comb begin
    n_cfg = (32'(cfg.level_count) > MAX_LEVELS) ? OCT_W'(MAX_LEVELS)
                                                : OCT_W'(cfg.level_count);
  end

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    part_nxt      = part_r;
    oct_nxt       = oct_r;
    n_nxt         = n_r;
    fcnt_nxt      = fcnt_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    head_pop      = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = {oct_r[LVL_W-1:0], f_hash[TABLE_BITS-1:0]};
    unique case (state_r)
      S_IDLE: begin
        mem_addr = {LVL_W'(4'(head_cmd.level_index)),
                    head_cmd.table_address[TABLE_BITS-1:0]};
        if (head_valid) begin
          head_pop = 1'b1;
          if (head_cmd.operation == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            n_nxt    = n_cfg;
            oct_nxt  = '0;
            axis_nxt = 2'd0;
            part_nxt = 2'd0;
            state_nxt = (n_cfg == '0) ? S_DONE : S_MUL;
          end
        end
      end
      S_MUL: begin
        if (part_r == 2'd2) begin
          part_nxt = 2'd0;
          if (axis_r == 2'd2) begin
            state_nxt = S_SPLIT;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      S_SPLIT: state_nxt = S_HASH1;
      S_HASH1: state_nxt = S_HASH2;
      S_HASH2: begin
        fcnt_nxt  = 4'd0;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        fcnt_nxt = fcnt_r + 4'd1;
        if (fcnt_r == 4'd8) begin
          step_nxt  = 3'd0;
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd6) begin
          oct_nxt   = oct_r + OCT_W'(1);
          state_nxt = (oct_r + OCT_W'(1) == n_r) ? S_DONE : S_SPLIT;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 2'd0;
      part_r      <= 2'd0;
      oct_r       <= '0;
      n_r         <= '0;
      fcnt_r      <= 4'd0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
      sum_r       <= 25'd0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      part_r      <= part_nxt;
      oct_r       <= oct_nxt;
      n_r         <= n_nxt;
      fcnt_r      <= fcnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_IDLE) begin
        sum_r <= 25'd0;
      end else if (state_r == S_BLEND && step_r == 3'd6) begin
        sum_r <= sum_r + 25'(res_sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= head_cmd.table_data;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && head_valid) begin
      cx_r <= head_cmd.x_coord;
      cy_r <= head_cmd.y_coord;
      cz_r <= head_cmd.z_coord;
    end
    if (state_r == S_MUL) begin
      acc_r <= acc_nxt;
      if (part_r == 2'd2) begin
        case (axis_r)
          2'd0:    px_r <= acc_nxt;
          2'd1:    py_r <= acc_nxt;
          default: pz_r <= acc_nxt;
        endcase
      end
    end
    if (state_r == S_SPLIT) begin
      xi_r <= psx[71:40];
      xl_r <= psx[39:24];
      yi_r <= psy[71:40];
      yl_r <= psy[39:24];
      zi_r <= psz[71:40];
      zl_r <= psz[39:24];
    end
    if (state_r == S_HASH1) begin
      x0_r <= 32'(xi_r * HASH_MUL_X);
    end
    if (state_r == S_HASH2) begin
      h00_r <= 32'((x0_r + yi_r) * HASH_MUL_Y);
      h10_r <= 32'((x0_r + HASH_MUL_X + yi_r) * HASH_MUL_Y);
    end
    if (state_r == S_FETCH && fcnt_r != 4'd0) begin
      byte_r[3'(fcnt_r - 4'd1)] <= rd_data_r;
    end
    if (state_r == S_BLEND) begin
      byte_r[b_dst] <= b_res;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      noise_r <= sum_r;
    end
  end

endmodule
